// ===== rtl/core/utf8ld_pkg.sv =====
// Shared types and constants for the lenient UTF-8 decoder.
`timescale 1ns / 1ps

package utf8ld_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int PEND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_CHAR  = 2'd0;
    localparam logic [STAT_W-1:0] ST_TRUNC = 2'd1;
    localparam logic [STAT_W-1:0] ST_END   = 2'd2;

    typedef struct packed {
        logic [PEND_W-1:0] pending;
        logic [CP_W-1:0]   acc;
    } dec_state_t;

    typedef struct packed {
        logic              valid;
        logic [CP_W-1:0]   code_point;
        logic [STAT_W-1:0] status;
    } dec_result_t;

    typedef struct packed {
        logic              end_marker;
        logic [BYTE_W-1:0] in_byte;
    } dec_item_t;

endpackage

// ===== rtl/core/utf8_lenient_decoder_top.sv =====
// Top level of the lenient UTF-8 decoder.
//
// The slave channel takes one byte per transfer: s_tdata[7:0] is the byte,
// s_tuser[0] marks end of text (the byte is then ignored). The master channel
// returns one result per finished character or end marker: m_tdata[20:0] is
// the code point, m_tuser[1:0] the status (character, truncated, end).
// A lead byte produces no result; its sequence completes on the last byte.
// A byte passes the input register and the decode step and lands in the result
// register. The block accepts one byte every cycle unless a result waits on a
// low m_tready and the new byte would produce another result.
// A held result does not block the input: the next byte is still decoded in
// the same cycle the result is taken, and a byte that yields no result moves
// on even while the result register is full.
// Synchronous reset clears both valid flags, the pending count and the
// accumulator. While m_tready is low with a result waiting, a byte that would
// produce a result waits in the input register and s_tready drops.
`timescale 1ns / 1ps

module utf8_lenient_decoder_top
    import utf8ld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] end_marker
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    dec_item_t   s_item;
    dec_item_t   item;
    logic        item_valid;
    logic        advance;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t result;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CP_W-1:0]   out_cp_reg;
    logic [STAT_W-1:0] out_stat_reg;
    logic              out_free;

    assign s_item.in_byte    = s_tdata;
    assign s_item.end_marker = s_tuser[0];

    utf8ld_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    utf8ld_decode u_decode (
        .item       (item),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = item_valid && (!result.valid || out_free);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && result.valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_cp_reg   <= result.code_point;
            out_stat_reg <= result.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_cp_reg};
    assign m_tuser  = out_stat_reg;

endmodule

// ===== rtl/core/utf8ld_in_stage.sv =====
// Input register stage: holds one accepted byte until the decoder takes it.
`timescale 1ns / 1ps

module utf8ld_in_stage
    import utf8ld_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dec_item_t s_item,
    input  logic      advance,
    output logic      item_valid,
    output dec_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    dec_item_t item_reg;

    // A new transfer is taken whenever the register is empty or the held item leaves in this cycle.
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/utf8ld_decode.sv =====
// Single-step decode logic: next state and optional result for one item.
`timescale 1ns / 1ps

module utf8ld_decode
    import utf8ld_pkg::*;
(
    input  dec_item_t   item,
    input  dec_state_t  state,
    output dec_state_t  state_next,
    output dec_result_t result
);

    logic [BYTE_W-1:0] b;
    logic [CP_W-1:0]   cont_bits;
    logic [CP_W-1:0]   acc_merged;

    assign b = item.in_byte;

    always_comb begin
        case (state.pending)
            2'd1:    cont_bits = {15'd0, b[5:0]};
            2'd2:    cont_bits = {9'd0, b[5:0], 6'd0};
            2'd3:    cont_bits = {3'd0, b[5:0], 12'd0};
            default: cont_bits = '0;
        endcase
    end

    assign acc_merged = state.acc | cont_bits;

    always_comb begin
        state_next        = state;
        result.valid      = 1'b0;
        result.code_point = '0;
        result.status     = ST_CHAR;

        if (item.end_marker) begin
            result.valid = 1'b1;
            if (state.pending != '0) begin
                result.status    = ST_TRUNC;
                state_next.pending = '0;
                state_next.acc     = '0;
            end else begin
                result.status = ST_END;
            end
        end else if (state.pending != '0) begin
            // Any byte here is a continuation; its top bits are ignored.
            state_next.pending = state.pending - 2'd1;
            if (state.pending == 2'd1) begin
                result.valid      = 1'b1;
                result.code_point = acc_merged;
                state_next.acc    = '0;
            end else begin
                state_next.acc = acc_merged;
            end
        end else if (b[7] == 1'b0) begin
            result.valid      = 1'b1;
            result.code_point = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
            state_next.pending = 2'd1;
            state_next.acc     = {10'd0, b[4:0], 6'd0};
        end else if (b[7:4] == 4'b1110) begin
            state_next.pending = 2'd2;
            state_next.acc     = {5'd0, b[3:0], 12'd0};
        end else if (b[7:3] == 5'b11110) begin
            state_next.pending = 2'd3;
            state_next.acc     = {b[2:0], 18'd0};
        end else begin
            // Stray continuation or invalid lead byte passes through as is.
            result.valid      = 1'b1;
            result.code_point = {13'd0, b};
        end
    end

endmodule
